// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked assertion, muted while reset is asserted.
`define HRP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// A stalled word keeps the given signal until it is taken.
`define HRP_ASSERT_HOLD(label, clk, rst_n, vld, rdy, sig, msg) \
	`HRP_ASSERT(label, clk, rst_n, vld && !rdy |=> vld && $stable(sig), msg)

`endif

// ===== design/hrp_pkg.sv =====
`timescale 1ns / 1ps

package hrp_pkg;

	localparam int BYTE_W   = 8;
	localparam int ROLE_W   = 2;
	localparam int STATUS_W = 10;
	localparam int ERR_W    = 3;
	localparam int LINE_W   = 16;

	localparam logic [BYTE_W-1:0] CH_CR    = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3a;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CH_H     = 8'h48;
	localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
	localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
	localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2f;
	localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2e;
	localparam logic [BYTE_W-1:0] CH_0     = 8'h30;
	localparam logic [BYTE_W-1:0] CH_1     = 8'h31;
	localparam logic [BYTE_W-1:0] CH_9     = 8'h39;

	localparam logic [STATUS_W-1:0] STATUS_RESET   = 10'd500;
	localparam logic [LINE_W-1:0]   MAX_LINE_RESET = 16'd4096;

	localparam logic [ROLE_W-1:0] ROLE_FRAME = 2'd0;
	localparam logic [ROLE_W-1:0] ROLE_NAME  = 2'd1;
	localparam logic [ROLE_W-1:0] ROLE_VALUE = 2'd2;
	localparam logic [ROLE_W-1:0] ROLE_BODY  = 2'd3;

	localparam logic [ERR_W-1:0] ERR_NONE   = 3'd0;
	localparam logic [ERR_W-1:0] ERR_STATUS = 3'd1;
	localparam logic [ERR_W-1:0] ERR_LONG   = 3'd2;
	localparam logic [ERR_W-1:0] ERR_CONT   = 3'd3;
	localparam logic [ERR_W-1:0] ERR_COLON  = 3'd4;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [2:0] {
		PH_STATUS = 3'b001,
		PH_HEADER = 3'b010,
		PH_BODY   = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		HP_NAME  = 3'b001,
		HP_SKIP  = 3'b010,
		HP_VALUE = 3'b100
	} hdr_part_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic [ROLE_W-1:0]   byte_role;
		logic                header_complete;
		logic                headers_finished;
		logic                in_body;
		logic                status_valid;
		logic [STATUS_W-1:0] status_code;
		logic [ERR_W-1:0]    error_code;
		logic                last_of_run;
	} word_t;

endpackage

// ===== design/hrp_in_if.sv =====
`timescale 1ns / 1ps

interface hrp_in_if;
	import hrp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

// ===== design/hrp_out_if.sv =====
`timescale 1ns / 1ps

interface hrp_out_if;
	import hrp_pkg::*;

	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   out_byte;
	logic [ROLE_W-1:0]   byte_role;
	logic                header_complete;
	logic                headers_finished;
	logic                in_body;
	logic                status_valid;
	logic [STATUS_W-1:0] status_code;
	logic [ERR_W-1:0]    error_code;
	logic                last_of_run;

	modport source (
		output valid, output out_byte, output byte_role, output header_complete,
		output headers_finished, output in_body, output status_valid,
		output status_code, output error_code, output last_of_run, input ready
	);
	modport sink (
		input valid, input out_byte, input byte_role, input header_complete,
		input headers_finished, input in_body, input status_valid,
		input status_code, input error_code, input last_of_run, output ready
	);
endinterface

// ===== design/http_response_header_parser.sv =====
`timescale 1ns / 1ps
// HTTP/1.x response header parser.
// in_ch  : one response byte per word (valid/ready, taken when both are high).
// out_ch : words describing bytes: role (framing, header name, header value,
//          body), line-end flags, and the parser status after that byte.
// cfg_wr_en/cfg_wr_data set the largest line length (CRLF included); write it
// only while the parser is idle. Reset value is 4096.
// A byte is parsed in the cycle it is taken and its words land in a 4-entry
// output queue, which registers them before they show on out_ch.
// One byte a cycle is taken while the queue has room for two words; a CR is
// held back until the next byte, so a byte yields zero, one or two words and
// the output side (one word a cycle) sets the rate when CRs are flushed.
// last_of_run marks the final word of a byte.
// If the receiver stalls, the queue fills and in_ch.ready drops; nothing is
// lost. Reset empties the queue, puts the parser at the status line with
// status code 500 and clears any error. Errors stick until reset; after one,
// every byte gives a single framing word carrying the error code.
module http_response_header_parser (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [hrp_pkg::LINE_W-1:0] cfg_wr_data,
	hrp_in_if.sink                    in_ch,
	hrp_out_if.source                 out_ch
);
	import hrp_pkg::*;

	// parser state
	logic [LINE_W-1:0]   max_q;
	phase_t              ph_q, ph_d;
	logic [LINE_W-1:0]   lc_q, lc_d;
	logic                good_q, good_d;
	logic [STATUS_W-1:0] acc_q, acc_d;
	logic [STATUS_W-1:0] held_q, held_d;
	hdr_part_t           hp_q, hp_d;
	logic                cont_q, cont_d;
	logic                cr_q, cr_d;
	logic [ERR_W-1:0]    fail_q, fail_d;

	// output queue
	word_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;

	logic              in_acc, out_acc;
	logic [1:0]        n_words;
	logic [1:0]        push_n;
	word_t             w0, w1;
	logic [BYTE_W-1:0] b;

	assign b       = in_ch.in_byte;
	assign in_acc  = in_ch.valid && in_ch.ready;
	assign out_acc = out_ch.valid && out_ch.ready;
	assign push_n  = in_acc ? n_words : 2'd0;

	always_comb begin
		logic              ws, ok, chk, good_n, hc, hf;
		logic [STATUS_W-1:0] acc_n;
		logic [13:0]       acc_x10;
		logic [3:0]        digit;
		logic [ROLE_W-1:0] role_cr, role_b;
		hdr_part_t         hp1, hp2;
		logic [BYTE_W-1:0] w0_byte, w1_byte;
		logic [ROLE_W-1:0] w0_role, w1_role;

		ph_d    = ph_q;
		lc_d    = lc_q;
		good_d  = good_q;
		acc_d   = acc_q;
		held_d  = held_q;
		hp_d    = hp_q;
		cont_d  = cont_q;
		cr_d    = cr_q;
		fail_d  = fail_q;
		n_words = 2'd0;
		w0_byte = b;
		w0_role = ROLE_FRAME;
		w1_byte = b;
		w1_role = ROLE_FRAME;
		hc      = 1'b0;
		hf      = 1'b0;
		ws      = (b == CH_SPACE) || (b == CH_TAB);
		ok      = 1'b1;
		chk     = 1'b1;
		digit   = b[3:0];
		acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
		good_n  = good_q;
		acc_n   = acc_q;
		role_cr = ROLE_FRAME;
		role_b  = ROLE_FRAME;
		hp1     = hp_q;
		hp2     = hp_q;

		if (fail_q != ERR_NONE) begin
			n_words = 2'd1;
		end else if (ph_q == PH_BODY) begin
			n_words = 2'd1;
			w0_role = ROLE_BODY;
		end else if (lc_q >= max_q) begin
			if (cr_q) begin
				n_words = 2'd2;
				w0_byte = CH_CR;
			end else begin
				n_words = 2'd1;
			end
			cr_d   = 1'b0;
			fail_d = ERR_LONG;
		end else begin
			lc_d = lc_q + 1'b1;
			if (ph_q == PH_STATUS) begin
				unique case (lc_q)
					16'd0:          ok = (b == CH_H);
					16'd1, 16'd2:   ok = (b == CH_T);
					16'd3:          ok = (b == CH_P);
					16'd4:          ok = (b == CH_SLASH);
					16'd5:          ok = (b == CH_1);
					16'd6:          ok = (b == CH_DOT);
					16'd7:          ok = (b == CH_0) || (b == CH_1);
					16'd8, 16'd12:  ok = (b == CH_SPACE);
					16'd9:          ok = (b >= CH_1) && (b <= CH_9);
					16'd10, 16'd11: ok = (b >= CH_0) && (b <= CH_9);
					default:        chk = 1'b0;
				endcase
				if (chk && !ok)
					good_n = 1'b0;
				// digits of the code: positions 9 to 11
				if (chk && ok && lc_q >= 16'd9 && lc_q <= 16'd11)
					acc_n = acc_x10[STATUS_W-1:0] + {6'd0, digit};
				good_d = good_n;
				acc_d  = acc_n;
			end else if (lc_q == '0 && ws) begin
				cont_d = 1'b1;
			end

			if (b == CH_LF && cr_q) begin
				n_words = 2'd2;
				w0_byte = CH_CR;
				if (ph_q == PH_STATUS) begin
					if (good_n) begin
						held_d = acc_n;
						ph_d   = PH_HEADER;
					end else begin
						fail_d = ERR_STATUS;
					end
				end else if (lc_q == 16'd1) begin
					ph_d = PH_BODY;
					hf   = 1'b1;
				end else if (cont_d) begin
					fail_d = ERR_CONT;
				end else if (hp_q == HP_NAME) begin
					fail_d = ERR_COLON;
				end else begin
					hc = 1'b1;
				end
				lc_d   = '0;
				hp_d   = HP_NAME;
				cont_d = 1'b0;
				good_d = 1'b1;
				acc_d  = '0;
				cr_d   = 1'b0;
			end else begin
				// flush a held CR with the role it has at its place
				if (cr_q) begin
					if (ph_q == PH_HEADER) begin
						role_cr = (hp_q == HP_NAME) ? ROLE_NAME : ROLE_VALUE;
						if (hp_q == HP_SKIP)
							hp1 = HP_VALUE;
					end
					cr_d = 1'b0;
				end
				hp2 = hp1;
				if (ph_q == PH_HEADER) begin
					unique case (hp1)
						HP_NAME: begin
							if (b == CH_COLON) begin
								role_b = ROLE_FRAME;
								hp2    = HP_SKIP;
							end else begin
								role_b = ROLE_NAME;
							end
						end
						HP_SKIP: begin
							if (ws) begin
								role_b = ROLE_FRAME;
							end else begin
								role_b = ROLE_VALUE;
								hp2    = HP_VALUE;
							end
						end
						HP_VALUE: role_b = ROLE_VALUE;
						default:  role_b = ROLE_FRAME;
					endcase
				end
				if (b == CH_CR) begin
					cr_d = 1'b1;
					hp2  = hp1;
				end
				hp_d = hp2;

				if (cr_q) begin
					w0_byte = CH_CR;
					w0_role = role_cr;
					w1_role = role_b;
					n_words = (b == CH_CR) ? 2'd1 : 2'd2;
				end else begin
					w0_role = role_b;
					n_words = (b == CH_CR) ? 2'd0 : 2'd1;
				end
			end
		end

		w0.out_byte         = w0_byte;
		w0.byte_role        = w0_role;
		w0.header_complete  = 1'b0;
		w0.headers_finished = 1'b0;
		w0.in_body          = (ph_d == PH_BODY);
		w0.status_valid     = (ph_d != PH_STATUS);
		w0.status_code      = held_d;
		w0.error_code       = fail_d;
		w0.last_of_run      = (n_words == 2'd1);

		w1                  = w0;
		w1.out_byte         = w1_byte;
		w1.byte_role        = w1_role;
		w1.header_complete  = hc;
		w1.headers_finished = hf;
		w1.last_of_run      = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= MAX_LINE_RESET;
			ph_q   <= PH_STATUS;
			lc_q   <= '0;
			good_q <= 1'b1;
			acc_q  <= '0;
			held_q <= STATUS_RESET;
			hp_q   <= HP_NAME;
			cont_q <= 1'b0;
			cr_q   <= 1'b0;
			fail_q <= ERR_NONE;
		end else begin
			if (cfg_wr_en)
				max_q <= cfg_wr_data;
			if (in_acc) begin
				ph_q   <= ph_d;
				lc_q   <= lc_d;
				good_q <= good_d;
				acc_q  <= acc_d;
				held_q <= held_d;
				hp_q   <= hp_d;
				cont_q <= cont_d;
				cr_q   <= cr_d;
				fail_q <= fail_d;
			end
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push_n);
			if (out_acc)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(push_n) - CNT_W'(out_acc);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && n_words != 2'd0)
			fifo_q[wr_q] <= w0;
		if (in_acc && n_words == 2'd2)
			fifo_q[wr_q + 1'b1] <= w1;
	end

	// room for the two words a byte may produce
	assign in_ch.ready = (cnt_q <= CNT_W'(FIFO_DEPTH - 2));

	assign out_ch.valid            = (cnt_q != '0);
	assign out_ch.out_byte         = fifo_q[rd_q].out_byte;
	assign out_ch.byte_role        = fifo_q[rd_q].byte_role;
	assign out_ch.header_complete  = fifo_q[rd_q].header_complete;
	assign out_ch.headers_finished = fifo_q[rd_q].headers_finished;
	assign out_ch.in_body          = fifo_q[rd_q].in_body;
	assign out_ch.status_valid     = fifo_q[rd_q].status_valid;
	assign out_ch.status_code      = fifo_q[rd_q].status_code;
	assign out_ch.error_code       = fifo_q[rd_q].error_code;
	assign out_ch.last_of_run      = fifo_q[rd_q].last_of_run;

endmodule

// ===== design/hrp_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hrp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [hrp_pkg::BYTE_W-1:0]   out_byte,
	input logic [hrp_pkg::ROLE_W-1:0]   byte_role,
	input logic                         header_complete,
	input logic                         headers_finished,
	input logic                         in_body,
	input logic [hrp_pkg::ERR_W-1:0]    error_code,
	input logic                         last_of_run
);
	import hrp_pkg::*;

	logic             out_acc;
	logic [ERR_W-1:0] err_q;
	logic             body_q;

	assign out_acc = out_valid && out_ready;

	// last error code seen, and whether the blank line's LF has gone out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q  <= ERR_NONE;
			body_q <= 1'b0;
		end else if (out_acc) begin
			err_q  <= error_code;
			body_q <= body_q || headers_finished;
		end
	end

	`HRP_ASSERT_HOLD(a_out_hold, clk, arst_n, out_valid, out_ready, out_byte, "stalled word changed")

	`HRP_ASSERT(a_err_sticky, clk, arst_n, out_acc && err_q != ERR_NONE |-> error_code == err_q, "error code did not stick")

	`HRP_ASSERT(a_body_role, clk, arst_n, out_acc && body_q |-> byte_role == ROLE_BODY && error_code == ERR_NONE && in_body, "body word with wrong role")

	`HRP_ASSERT(a_line_end, clk, arst_n, out_acc && (header_complete || headers_finished) |-> out_byte == CH_LF && last_of_run && byte_role == ROLE_FRAME, "line-end flag off an LF")

endmodule

bind http_response_header_parser hrp_checker u_hrp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_byte         (out_ch.out_byte),
	.byte_role        (out_ch.byte_role),
	.header_complete  (out_ch.header_complete),
	.headers_finished (out_ch.headers_finished),
	.in_body          (out_ch.in_body),
	.error_code       (out_ch.error_code),
	.last_of_run      (out_ch.last_of_run)
);
